FILE: src/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types, codes and constants of the GIF LZW decoder unit.
// ----------------------------------------------------------------------------
package gld_pkg;

  // Widest LZW code and the table / stack depth that follows from it
  localparam int MAX_CODE_WIDTH = 12;
  localparam int TABLE_SIZE     = 1 << MAX_CODE_WIDTH;
  localparam int SLOT_W         = MAX_CODE_WIDTH + 1;
  localparam int RES_W          = 24;
  localparam int RES_CNT_W      = 5;

  localparam logic [SLOT_W-1:0] TABLE_FULL = SLOT_W'(TABLE_SIZE);
  localparam logic [3:0]        CW_MAX     = 4'(MAX_CODE_WIDTH);

  // Configuration register indexes
  localparam logic CFG_MIN_CODE_SIZE = 1'b0;
  localparam logic CFG_LINE_WIDTH    = 1'b1;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_TAKEN     = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_PIXEL     = 3'd3,
    ST_NEED      = 3'd4,
    ST_DONE      = 3'd5,
    ST_TRUNCATED = 3'd6,
    ST_CORRUPTED = 3'd7
  } status_t;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_BYTE,
    CMD_BADOP,
    CMD_ERR_ANS,
    CMD_POP_RD,
    CMD_DONE_ANS,
    CMD_NEED,
    CMD_END_CODE,
    CMD_CLEAR,
    CMD_FIRST,
    CMD_CODE,
    CMD_WALK_PUSH,
    CMD_FINISH,
    CMD_EMIT
  } cmd_t;

  // Status flags from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       slot_free;
    logic       err;
    logic       depth_nz;
    logic       ended;
    logic       res_short;
    logic       is_end;
    logic       is_clear;
    logic       after_clear;
    logic       walk_go;
  } dp_stat_t;

endpackage

FILE: src/gld_in_if.sv
// ----------------------------------------------------------------------------
// gld_in_if
// Input item channel: valid/ready handshake with opcode and stream byte.
// ----------------------------------------------------------------------------
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

FILE: src/gld_out_if.sv
// ----------------------------------------------------------------------------
// gld_out_if
// Result item channel: valid/ready handshake with status, pixel and counters.
// ----------------------------------------------------------------------------
interface gld_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  pixel;
  logic        line_end;
  logic [15:0] column;
  logic [15:0] bad_codes;

  modport source (output valid, output status, output pixel, output line_end,
                  output column, output bad_codes, input ready);
  modport sink   (input valid, input status, input pixel, input line_end,
                  input column, input bad_codes, output ready);
endinterface

FILE: src/gld_ctrl.sv
// ----------------------------------------------------------------------------
// gld_ctrl
// Controller state machine: sequences each item through the datapath.
// ----------------------------------------------------------------------------
module gld_ctrl
  import gld_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_CODE  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_WRD   = 7'b0010000,
    S_POPRD = 7'b0100000,
    S_POP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.slot_free) begin
          unique case (stat.op)
            OP_START: begin
              cmd       = CMD_START;
              state_nxt = S_IDLE;
            end
            OP_BYTE: begin
              cmd       = CMD_BYTE;
              state_nxt = S_IDLE;
            end
            OP_FETCH: begin
              if (stat.err) begin
                cmd       = CMD_ERR_ANS;
                state_nxt = S_IDLE;
              end else if (stat.depth_nz) begin
                cmd       = CMD_POP_RD;
                state_nxt = S_POP;
              end else if (stat.ended) begin
                cmd       = CMD_DONE_ANS;
                state_nxt = S_IDLE;
              end else begin
                state_nxt = S_CODE;
              end
            end
            default: begin
              cmd       = CMD_BADOP;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CODE: begin
        if (stat.res_short) begin
          cmd       = CMD_NEED;
          state_nxt = S_IDLE;
        end else if (stat.is_end) begin
          cmd       = CMD_END_CODE;
          state_nxt = S_IDLE;
        end else if (stat.is_clear) begin
          cmd = CMD_CLEAR;
        end else if (stat.after_clear) begin
          cmd       = CMD_FIRST;
          state_nxt = S_IDLE;
        end else begin
          cmd       = CMD_CODE;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_go) begin
          state_nxt = S_WRD;
        end else begin
          cmd       = CMD_FINISH;
          state_nxt = S_POPRD;
        end
      end
      S_WRD: begin
        cmd       = CMD_WALK_PUSH;
        state_nxt = S_WALK;
      end
      S_POPRD: begin
        cmd       = CMD_POP_RD;
        state_nxt = S_POP;
      end
      S_POP: begin
        cmd       = CMD_EMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/gld_dp.sv
// ----------------------------------------------------------------------------
// gld_dp
// Datapath: bit reservoir, code table, pixel stack, counters and result slot.
// ----------------------------------------------------------------------------
module gld_dp
  import gld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_pixel,
  output logic        out_line_end,
  output logic [15:0] out_column,
  output logic [15:0] out_bad_codes
);

  localparam int AW = MAX_CODE_WIDTH;

  // Configuration registers
  logic [3:0]  min_size_r;
  logic [15:0] line_width_r;

  // Latched item
  logic [1:0] op_r;
  logic [7:0] byte_r;

  // Decoder state
  logic [RES_W-1:0]     res_r, res_nxt;
  logic [RES_CNT_W-1:0] bits_r, bits_nxt;
  logic [7:0]           bbl_r, bbl_nxt;
  logic [3:0]           cw_r, cw_nxt;
  logic [SLOT_W-1:0]    limit_r, limit_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]        prev_r, prev_nxt;
  logic [7:0]           first_r, first_nxt;
  logic                 aclr_r, aclr_nxt;
  logic                 ended_r, ended_nxt;
  logic                 err_r, err_nxt;
  status_t              kind_r, kind_nxt;
  logic                 closed_r, closed_nxt;
  logic [3:0]           root_r, root_nxt;
  logic [SLOT_W-1:0]    depth_r, depth_nxt;
  logic [15:0]          col_r, col_nxt;
  logic [15:0]          bad_r, bad_nxt;
  logic [AW-1:0]        code_r, code_nxt;
  logic [AW-1:0]        cur_r, cur_nxt;

  // Result slot
  logic        ov_r, ov_nxt;
  status_t     ost_r, ost_nxt;
  logic [7:0]  opix_r, opix_nxt;
  logic        olend_r, olend_nxt;
  logic [15:0] ocol_r, ocol_nxt;
  logic [15:0] obad_r, obad_nxt;

  // Memories
  logic [7:0]    stack_mem  [TABLE_SIZE];
  logic [AW-1:0] prefix_mem [TABLE_SIZE];
  logic [7:0]    suffix_mem [TABLE_SIZE];
  logic [7:0]    stack_q;
  logic [AW-1:0] prefix_q;
  logic [7:0]    suffix_q;

  logic          push_en;
  logic [7:0]    push_data;
  logic          tab_we;
  logic [AW-1:0] tab_addr;
  logic [7:0]    tab_suf;
  logic [AW-1:0] tab_pre;

  // Derived values
  logic [SLOT_W-1:0] clear_code, end_code, first_free, code13, slot_inc;
  logic [AW-1:0]     code_w;
  logic              slot_free;
  logic [15:0]       col_inc;
  logic              size_ok;

  assign clear_code = SLOT_W'(1) << root_r;
  assign end_code   = clear_code + SLOT_W'(1);
  assign first_free = clear_code + SLOT_W'(2);
  assign code_w     = res_r[AW-1:0] & ~({AW{1'b1}} << cw_r);
  assign code13     = {1'b0, code_w};
  assign slot_free  = !ov_r || out_ready;
  assign col_inc    = col_r + 16'd1;
  assign size_ok    = (min_size_r >= 4'd2) && (min_size_r <= 4'd9);
  assign slot_inc   = slot_r + SLOT_W'(1);

  // Status to the controller
  always_comb begin
    stat.op          = op_r;
    stat.slot_free   = slot_free;
    stat.err         = err_r;
    stat.depth_nz    = depth_r != '0;
    stat.ended       = ended_r;
    stat.res_short   = {1'b0, bits_r} < {2'b00, cw_r};
    stat.is_end      = code13 == end_code;
    stat.is_clear    = code13 == clear_code;
    stat.after_clear = aclr_r;
    stat.walk_go     = ({1'b0, cur_r} >= first_free) && (depth_r < TABLE_FULL);
  end

  // Command execution
  always_comb begin
    res_nxt    = res_r;
    bits_nxt   = bits_r;
    bbl_nxt    = bbl_r;
    cw_nxt     = cw_r;
    limit_nxt  = limit_r;
    slot_nxt   = slot_r;
    prev_nxt   = prev_r;
    first_nxt  = first_r;
    aclr_nxt   = aclr_r;
    ended_nxt  = ended_r;
    err_nxt    = err_r;
    kind_nxt   = kind_r;
    closed_nxt = closed_r;
    root_nxt   = root_r;
    depth_nxt  = depth_r;
    col_nxt    = col_r;
    bad_nxt    = bad_r;
    code_nxt   = code_r;
    cur_nxt    = cur_r;
    ov_nxt     = ov_r && !out_ready;
    ost_nxt    = ost_r;
    opix_nxt   = 8'd0;
    olend_nxt  = 1'b0;
    push_en    = 1'b0;
    push_data  = first_r;
    tab_we     = 1'b0;
    tab_addr   = slot_r[AW-1:0];
    tab_suf    = cur_r[7:0];
    tab_pre    = prev_r;
    case (cmd)
      CMD_START: begin
        ov_nxt = 1'b1;
        if (!size_ok) begin
          err_nxt  = 1'b1;
          kind_nxt = ST_CORRUPTED;
          ost_nxt  = ST_CORRUPTED;
        end else begin
          root_nxt   = min_size_r;
          res_nxt    = '0;
          bits_nxt   = '0;
          bbl_nxt    = '0;
          cw_nxt     = min_size_r + 4'd1;
          limit_nxt  = SLOT_W'(1) << (min_size_r + 4'd1);
          slot_nxt   = (SLOT_W'(1) << min_size_r) + SLOT_W'(2);
          prev_nxt   = '0;
          first_nxt  = '0;
          aclr_nxt   = 1'b0;
          ended_nxt  = 1'b0;
          err_nxt    = 1'b0;
          kind_nxt   = ST_STARTED;
          closed_nxt = 1'b0;
          depth_nxt  = '0;
          col_nxt    = '0;
          bad_nxt    = '0;
          ost_nxt    = ST_STARTED;
        end
      end
      CMD_BYTE: begin
        ov_nxt  = 1'b1;
        ost_nxt = ST_TAKEN;
        if (err_r || ended_r || closed_r) begin
          ost_nxt = ST_REFUSED;
        end else if (bbl_r == 8'd0) begin
          // sub-block length byte; zero closes the stream
          if (byte_r == 8'd0) begin
            closed_nxt = 1'b1;
          end else begin
            bbl_nxt = byte_r;
          end
        end else if (bits_r > RES_CNT_W'(16)) begin
          ost_nxt = ST_REFUSED;
        end else begin
          res_nxt  = res_r | (RES_W'(byte_r) << bits_r);
          bits_nxt = bits_r + RES_CNT_W'(8);
          bbl_nxt  = bbl_r - 8'd1;
        end
      end
      CMD_BADOP: begin
        ov_nxt  = 1'b1;
        ost_nxt = ST_REFUSED;
      end
      CMD_ERR_ANS: begin
        ov_nxt  = 1'b1;
        ost_nxt = kind_r;
      end
      CMD_DONE_ANS, CMD_END_CODE: begin
        ov_nxt  = 1'b1;
        ost_nxt = ST_DONE;
        if (cmd == CMD_END_CODE) begin
          ended_nxt = 1'b1;
          res_nxt   = res_r >> cw_r;
          bits_nxt  = bits_r - RES_CNT_W'(cw_r);
        end
      end
      CMD_NEED: begin
        ov_nxt  = 1'b1;
        ost_nxt = ST_NEED;
        if (closed_r) begin
          err_nxt  = 1'b1;
          kind_nxt = ST_TRUNCATED;
          ost_nxt  = ST_TRUNCATED;
        end
      end
      CMD_CLEAR: begin
        res_nxt   = res_r >> cw_r;
        bits_nxt  = bits_r - RES_CNT_W'(cw_r);
        cw_nxt    = root_r + 4'd1;
        limit_nxt = SLOT_W'(1) << (root_r + 4'd1);
        slot_nxt  = first_free;
        aclr_nxt  = 1'b1;
      end
      CMD_FIRST: begin
        // first code after a clear is emitted directly
        res_nxt   = res_r >> cw_r;
        bits_nxt  = bits_r - RES_CNT_W'(cw_r);
        aclr_nxt  = 1'b0;
        prev_nxt  = (code13 >= slot_r) ? '0 : code_w;
        first_nxt = (code13 >= slot_r) ? 8'd0 : code_w[7:0];
        ov_nxt    = 1'b1;
        ost_nxt   = ST_PIXEL;
        opix_nxt  = first_nxt;
        col_nxt   = col_inc;
        if (col_inc == line_width_r) begin
          olend_nxt = 1'b1;
          col_nxt   = '0;
        end
      end
      CMD_CODE: begin
        res_nxt  = res_r >> cw_r;
        bits_nxt = bits_r - RES_CNT_W'(cw_r);
        code_nxt = code_w;
        cur_nxt  = code_w;
        if (code13 >= slot_r) begin
          if (code13 > slot_r && bad_r != 16'hFFFF) begin
            bad_nxt = bad_r + 16'd1;
          end
          cur_nxt   = prev_r;
          push_en   = depth_r < TABLE_FULL;
          push_data = first_r;
        end
      end
      CMD_WALK_PUSH: begin
        push_en   = 1'b1;
        push_data = suffix_q;
        cur_nxt   = prefix_q;
      end
      CMD_FINISH: begin
        push_en   = depth_r < TABLE_FULL;
        push_data = cur_r[7:0];
        if (slot_r < limit_r) begin
          tab_we   = 1'b1;
          slot_nxt = slot_inc;
        end
        prev_nxt  = code_r;
        first_nxt = cur_r[7:0];
        if (slot_nxt >= limit_r && cw_r < CW_MAX) begin
          limit_nxt = limit_r << 1;
          cw_nxt    = cw_r + 4'd1;
        end
      end
      CMD_POP_RD: begin
        depth_nxt = depth_r - SLOT_W'(1);
      end
      CMD_EMIT: begin
        ov_nxt   = 1'b1;
        ost_nxt  = ST_PIXEL;
        opix_nxt = stack_q;
        col_nxt  = col_inc;
        if (col_inc == line_width_r) begin
          olend_nxt = 1'b1;
          col_nxt   = '0;
        end
      end
      default: ;
    endcase
    if (push_en) begin
      depth_nxt = depth_r + SLOT_W'(1);
    end
    ocol_nxt = col_nxt;
    obad_nxt = bad_nxt;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r   <= 4'd8;
      line_width_r <= 16'd320;
      res_r        <= '0;
      bits_r       <= '0;
      bbl_r        <= '0;
      cw_r         <= 4'd9;
      limit_r      <= SLOT_W'(512);
      slot_r       <= SLOT_W'(258);
      prev_r       <= '0;
      first_r      <= '0;
      aclr_r       <= 1'b0;
      ended_r      <= 1'b0;
      err_r        <= 1'b0;
      kind_r       <= ST_STARTED;
      closed_r     <= 1'b0;
      root_r       <= 4'd8;
      depth_r      <= '0;
      col_r        <= '0;
      bad_r        <= '0;
      ov_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_CODE_SIZE) begin
          min_size_r <= cfg_data[3:0];
        end else begin
          line_width_r <= cfg_data;
        end
      end
      res_r    <= res_nxt;
      bits_r   <= bits_nxt;
      bbl_r    <= bbl_nxt;
      cw_r     <= cw_nxt;
      limit_r  <= limit_nxt;
      slot_r   <= slot_nxt;
      prev_r   <= prev_nxt;
      first_r  <= first_nxt;
      aclr_r   <= aclr_nxt;
      ended_r  <= ended_nxt;
      err_r    <= err_nxt;
      kind_r   <= kind_nxt;
      closed_r <= closed_nxt;
      root_r   <= root_nxt;
      depth_r  <= depth_nxt;
      col_r    <= col_nxt;
      bad_r    <= bad_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      op_r   <= in_opcode;
      byte_r <= in_data_byte;
    end
    code_r <= code_nxt;
    cur_r  <= cur_nxt;
    if (ov_nxt && !(ov_r && !out_ready)) begin
      ost_r   <= ost_nxt;
      opix_r  <= opix_nxt;
      olend_r <= olend_nxt;
      ocol_r  <= ocol_nxt;
      obad_r  <= obad_nxt;
    end
  end

  // Pixel stack: push at the top, read one below the top
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[depth_r[AW-1:0]] <= push_data;
    end
    stack_q <= stack_mem[depth_r[AW-1:0] - AW'(1)];
  end

  // Prefix and suffix tables, read at the current chain code
  always_ff @(posedge clk) begin
    if (tab_we) begin
      prefix_mem[tab_addr] <= tab_pre;
      suffix_mem[tab_addr] <= tab_suf;
    end
    prefix_q <= prefix_mem[cur_r];
    suffix_q <= suffix_mem[cur_r];
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_pixel     = opix_r;
  assign out_line_end  = olend_r;
  assign out_column    = ocol_r;
  assign out_bad_codes = obad_r;

endmodule

FILE: src/gif_lzw_decoder_unit.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit
// GIF LZW decoder: stream bytes in, one pixel or status per fetch out.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A start, a byte or a fetch that answers
// from the latched error or end state is answered in the execute state; a
// fetch served from the pixel stack pops it. A fetch that decodes the first
// code after a clear emits it directly; one that decodes another code walks
// the prefix chain, one push per link, then pops a pixel, and each clear
// code met on the way is consumed first. The chain walk is bound by the
// synchronous read of the prefix and suffix tables. Results sit in an output
// register, so a new item is taken while the previous result waits.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit
  import gld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gld_in_if.sink      in_ch,
  gld_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequencer
  gld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Decoding datapath
  gld_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_ch.opcode),
    .in_data_byte  (in_ch.data_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_pixel     (out_ch.pixel),
    .out_line_end  (out_ch.line_end),
    .out_column    (out_ch.column),
    .out_bad_codes (out_ch.bad_codes)
  );

endmodule

FILE: tb/lzw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_checker
// Watches the item channels and the register port of the GIF LZW decoder,
// keeps its own model of the decoder state, predicts one result per accepted
// item and compares every delivered result field by field, in order.
// ----------------------------------------------------------------------------
module lzw_checker
  import gld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gld_in_if           in_ch,
  gld_out_if          out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output logic [4:0]  res_level,
  output logic        stream_shut,
  output status_t     last_status
);

  typedef struct packed {
    status_t     status;
    logic [7:0]  pixel;
    logic        line_end;
    logic [15:0] column;
    logic [15:0] bad_codes;
  } px_result_t;

  px_result_t expected_px[$];

  // register copies
  logic [3:0]  mcs_reg;
  logic [15:0] lw_reg;

  // decoder state copy
  logic [23:0] reservoir;
  logic [4:0]  res_bits;
  logic [7:0]  blk_left;
  logic [3:0]  cw;
  logic [12:0] limit;
  logic [12:0] nslot;
  logic [11:0] prev_code;
  logic [7:0]  first_ch;
  logic        after_clr;
  logic        ended;
  logic        err;
  status_t     err_kind;
  logic        closed;
  logic [3:0]  root;
  logic [12:0] depth;
  logic [15:0] col;
  logic [15:0] bad;
  logic [7:0]  px_stack [TABLE_SIZE];
  logic [11:0] pre_tab  [TABLE_SIZE];
  logic [7:0]  suf_tab  [TABLE_SIZE];

  assign pending     = expected_px.size();
  assign res_level   = res_bits;
  assign stream_shut = ended | err | closed;

  function automatic px_result_t answer(status_t st, logic [7:0] pix, logic le);
    px_result_t r;
    r.status = st; r.pixel = pix; r.line_end = le; r.column = col; r.bad_codes = bad;
    return r;
  endfunction

  function automatic px_result_t emit_px(logic [7:0] pix);
    logic le;
    le  = 1'b0;
    col = col + 16'd1;
    if (col == lw_reg) begin
      le  = 1'b1;
      col = '0;
    end
    return answer(ST_PIXEL, pix, le);
  endfunction

  function automatic void push_px(int v);
    if (depth < TABLE_SIZE) begin
      px_stack[depth] = v[7:0];
      depth = depth + 13'd1;
    end
  endfunction

  function automatic void begin_image(logic [3:0] sz);
    root      = sz;
    reservoir = '0;
    res_bits  = '0;
    blk_left  = '0;
    cw        = sz + 4'd1;
    limit     = 13'd1 << cw;
    nslot     = (13'd1 << sz) + 13'd2;
    prev_code = '0;
    first_ch  = '0;
    after_clr = 1'b0;
    ended     = 1'b0;
    err       = 1'b0;
    err_kind  = ST_STARTED;
    closed    = 1'b0;
    depth     = '0;
    col       = '0;
    bad       = '0;
  endfunction

  // one fetch: stack pop, or code extraction and prefix-chain walk
  function automatic px_result_t fetch_px();
    int clr, eoi, ffree, code, cur;
    clr   = 1 << root;
    eoi   = clr + 1;
    ffree = clr + 2;
    if (err) return answer(err_kind, '0, 1'b0);
    if (depth > 0) begin
      depth = depth - 13'd1;
      return emit_px(px_stack[depth]);
    end
    if (ended) return answer(ST_DONE, '0, 1'b0);
    while (1'b1) begin
      if (res_bits < cw) begin
        if (closed) begin
          err      = 1'b1;
          err_kind = ST_TRUNCATED;
          return answer(ST_TRUNCATED, '0, 1'b0);
        end
        return answer(ST_NEED, '0, 1'b0);
      end
      code      = int'(reservoir) & ((1 << cw) - 1);
      reservoir = reservoir >> cw;
      res_bits  = res_bits - 5'(cw);
      if (code == eoi) begin
        ended = 1'b1;
        return answer(ST_DONE, '0, 1'b0);
      end
      if (code == clr) begin
        cw        = root + 4'd1;
        limit     = 13'd1 << cw;
        nslot     = 13'(ffree);
        after_clr = 1'b1;
        continue;
      end
      if (after_clr) begin
        if (code >= nslot) code = 0;
        prev_code = 12'(code);
        first_ch  = code[7:0];
        after_clr = 1'b0;
        return emit_px(code[7:0]);
      end
      cur = code;
      // code at or beyond the next slot: KwKwK case, bad ones counted
      if (code >= nslot) begin
        if (code > nslot && bad != 16'hFFFF) bad = bad + 16'd1;
        cur = prev_code;
        push_px(first_ch);
      end
      while (cur >= ffree && depth < TABLE_SIZE) begin
        push_px(suf_tab[cur & 4095]);
        cur = pre_tab[cur & 4095];
      end
      push_px(cur);
      if (nslot < limit) begin
        suf_tab[nslot[11:0]] = cur[7:0];
        pre_tab[nslot[11:0]] = prev_code;
        nslot = nslot + 13'd1;
      end
      prev_code = 12'(code & 4095);
      first_ch  = cur[7:0];
      if (nslot >= limit && cw < CW_MAX) begin
        limit = limit << 1;
        cw    = cw + 4'd1;
      end
      depth = depth - 13'd1;
      return emit_px(px_stack[depth]);
    end
    return answer(ST_NEED, '0, 1'b0);
  endfunction

  function automatic px_result_t take_byte(logic [7:0] b);
    if (err || ended || closed) return answer(ST_REFUSED, '0, 1'b0);
    if (blk_left == 0) begin
      if (b == 0) closed = 1'b1;
      else        blk_left = b;
      return answer(ST_TAKEN, '0, 1'b0);
    end
    if (res_bits > 16) return answer(ST_REFUSED, '0, 1'b0);
    reservoir = reservoir | (24'(b) << res_bits);
    res_bits  = res_bits + 5'd8;
    blk_left  = blk_left - 8'd1;
    return answer(ST_TAKEN, '0, 1'b0);
  endfunction

  function automatic px_result_t predict_item(logic [1:0] op, logic [7:0] b);
    case (op)
      OP_START: begin
        if (mcs_reg < 2 || mcs_reg > 9) begin
          err      = 1'b1;
          err_kind = ST_CORRUPTED;
          return answer(ST_CORRUPTED, '0, 1'b0);
        end
        begin_image(mcs_reg);
        return answer(ST_STARTED, '0, 1'b0);
      end
      OP_BYTE:  return take_byte(b);
      OP_FETCH: return fetch_px();
      default:  return answer(ST_REFUSED, '0, 1'b0);
    endcase
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    foreach (px_stack[i]) begin
      px_stack[i] = '0;
      pre_tab[i]  = '0;
      suf_tab[i]  = '0;
    end
    mcs_reg = 4'd8;
    lw_reg  = 16'd320;
    last_status = ST_STARTED;
    begin_image(4'd8);
  end

  // prediction on input items, comparison on result items
  always @(posedge clk) begin
    px_result_t exp_r, pred;
    if (!rst_n) begin
      mcs_reg = 4'd8;
      lw_reg  = 16'd320;
      begin_image(4'd8);
      expected_px.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_CODE_SIZE) mcs_reg = cfg_data[3:0];
        else                                lw_reg  = cfg_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: result item with nothing expected", $time);
          fail_count++;
        end else begin
          exp_r = expected_px.pop_front();
          if (out_ch.status !== exp_r.status)
            report("status", 16'(out_ch.status), 16'(exp_r.status));
          if (out_ch.pixel !== exp_r.pixel)
            report("pixel", 16'(out_ch.pixel), 16'(exp_r.pixel));
          if (out_ch.line_end !== exp_r.line_end)
            report("line_end", 16'(out_ch.line_end), 16'(exp_r.line_end));
          if (out_ch.column !== exp_r.column)
            report("column", out_ch.column, exp_r.column);
          if (out_ch.bad_codes !== exp_r.bad_codes)
            report("bad_codes", out_ch.bad_codes, exp_r.bad_codes);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = predict_item(in_ch.opcode, in_ch.data_byte);
        last_status = pred.status;
        expected_px.push_back(pred);
      end
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the GIF LZW decoder: directed corner cases, then encoded
// images of random content with clears, truncations and noise, under random
// idling on both channels and long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;
  import gld_pkg::*;

  localparam int WDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending;
  logic [4:0]  res_level;
  logic        stream_shut;
  status_t     last_status;
  int          items_sent = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [7:0]  gif_bytes[$];

  gld_in_if  in_ch();
  gld_out_if out_ch();

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_START;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
  end

  always #5 clk = ~clk;

  gif_lzw_decoder_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lzw_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .res_level(res_level),
    .stream_shut(stream_shut), .last_status(last_status)
  );

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 18);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one input item; called and returns at a falling edge
  task automatic send_item(op_t op, logic [7:0] b);
    while (idle_on && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // drain all results, then let the unit settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // LZW encoder tracking the decoder's slot count and code width
  task automatic encode_image(int sz, int npix, int palette, bit mid_clear, bit cut_end,
                              int max_blk);
    int dict[int];
    int clr, eoi, ffree, enc_next, dn, lim, cw, nth, w, c, acc, nacc, mc, n, i;
    int px[$];
    logic [7:0] packed_b[$];
    clr = 1 << sz; eoi = clr + 1; ffree = clr + 2;
    gif_bytes.delete();
    acc = 0; nacc = 0;
    for (i = 0; i < npix; i++) px.push_back($urandom_range(palette - 1));
    mc = mid_clear ? $urandom_range(1, npix) : npix + 5;
    // initial clear at the root width
    cw = sz + 1; lim = 1 << cw;
    acc |= clr << nacc; nacc += cw;
    enc_next = ffree; dn = ffree; nth = 0;
    w = px[0];
    for (i = 1; i <= npix; i++) begin
      c = (i < npix) ? px[i] : -1;
      if (c >= 0 && i != mc && dict.exists(w * 1024 + c)) begin
        w = dict[w * 1024 + c];
      end else begin
        acc |= w << nacc; nacc += cw;
        if (c >= 0 && i != mc && enc_next < TABLE_SIZE) begin
          dict[w * 1024 + c] = enc_next;
          enc_next++;
        end
        if (nth >= 1) begin
          if (dn < lim) dn++;
          if (dn >= lim && cw < MAX_CODE_WIDTH) begin
            lim <<= 1;
            cw++;
          end
        end
        nth++;
        if (i == mc) begin
          acc |= clr << nacc; nacc += cw;
          dict.delete();
          cw = sz + 1; lim = 1 << cw; enc_next = ffree; dn = ffree; nth = 0;
        end
        w = c;
      end
      while (nacc >= 8) begin
        packed_b.push_back(acc[7:0]);
        acc >>= 8; nacc -= 8;
      end
    end
    if (!cut_end) begin
      acc |= eoi << nacc; nacc += cw;
    end
    while (nacc > 0) begin
      packed_b.push_back(acc[7:0]);
      acc >>= 8; nacc = (nacc > 8) ? nacc - 8 : 0;
    end
    if (cut_end && packed_b.size() > 1) void'(packed_b.pop_back());
    // sub-blocks, then the zero-length terminator
    while (packed_b.size() > 0) begin
      n = $urandom_range(1, max_blk);
      if (n > packed_b.size()) n = packed_b.size();
      gif_bytes.push_back(8'(n));
      repeat (n) gif_bytes.push_back(packed_b.pop_front());
    end
    gif_bytes.push_back(8'd0);
  endtask

  // start, feed the stream while fetching, fetch to the end
  task automatic run_image(int tail_fetches);
    int guard;
    send_item(OP_START, 8'($urandom));
    foreach (gif_bytes[i]) begin
      guard = 0;
      while (res_level > 16 && !stream_shut && guard < 40) begin
        send_item(OP_FETCH, 8'($urandom));
        guard++;
      end
      if (stream_shut) break;
      send_item(OP_BYTE, gif_bytes[i]);
    end
    guard = 0;
    while (!(last_status inside {ST_DONE, ST_TRUNCATED, ST_CORRUPTED}) && guard < 6000) begin
      send_item(OP_FETCH, 8'($urandom));
      guard++;
    end
    repeat (tail_fetches) send_item(OP_FETCH, 8'($urandom));
  endtask

  task automatic noise_burst(int n);
    repeat (n) send_item(op_t'($urandom_range(3)), 8'($urandom));
  endtask

  task automatic set_config(int sz, int lw);
    drain();
    write_reg(CFG_MIN_CODE_SIZE, 16'(sz));
    write_reg(CFG_LINE_WIDTH, 16'(lw));
  endtask

  initial begin
    int sz, r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // straight out of reset: no data, odd opcode, stray bytes
    send_item(OP_FETCH, 8'h00);
    send_item(op_t'(2'd3), 8'hFF);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_FETCH, 8'h00);

    // bad minimum sizes latch corruption
    set_config(0, 1);
    send_item(OP_START, 8'h00);
    send_item(OP_FETCH, 8'h00);
    send_item(OP_BYTE, 8'h55);
    set_config(1, 65535);
    send_item(OP_START, 8'h00);
    set_config(10, 0);
    send_item(OP_START, 8'h00);
    set_config(15, 16'd3);
    send_item(OP_START, 8'h00);
    send_item(OP_FETCH, 8'h00);

    // smallest and largest root sizes, line widths 1, 0 and 65535
    set_config(2, 1);
    encode_image(2, 40, 4, 1'b1, 1'b0, 3);
    hold_req = 1'b1;
    run_image(2);
    set_config(9, 0);
    encode_image(9, 30, 512, 1'b0, 1'b0, 255);
    run_image(1);
    set_config(8, 65535);
    encode_image(8, 20, 256, 1'b0, 1'b1, 4);
    run_image(2);

    // random images and noise, with one pressure phase and one calm phase
    while (items_sent < 720) begin
      r  = $urandom_range(99);
      sz = $urandom_range(2, 9);
      set_config((r < 8) ? $urandom_range(15) : sz,
                 ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 12));
      if (r < 75) begin
        if (items_sent > 300 && items_sent < 400) hold_req = 1'b1;
        idle_on = !(items_sent > 450 && items_sent < 700);
        encode_image(sz, $urandom_range(1, 80), 1 << $urandom_range(1, sz),
                     $urandom_range(3) == 0, $urandom_range(7) == 0,
                     ($urandom_range(1) == 0) ? 6 : 255);
        run_image($urandom_range(2));
      end else begin
        idle_on = 1'b1;
        noise_burst($urandom_range(10, 30));
      end
    end
    idle_on = 1'b1;

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: gif_lzw_decoder_unit.f
src/gld_pkg.sv
src/gld_in_if.sv
src/gld_out_if.sv
src/gld_ctrl.sv
src/gld_dp.sv
src/gif_lzw_decoder_unit.sv
tb/lzw_checker.sv
tb/testbench.sv
